FILE: src/hclp_pkg.sv
// ----------------------------------------------------------------------------
// hclp_pkg: shared types and constants for the Content-Length header parser
// Parse phases, number-scanner state, line state, key text and byte codes.
// ----------------------------------------------------------------------------
package hclp_pkg;

  localparam int LengthBitsDef = 32;

  localparam logic [30:0] DefaultLengthRst = 31'd1000000;

  // "Content-Length" is 14 characters long
  localparam logic [3:0] KeyLen = 4'd14;

  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  localparam logic [1:0] PaddrIdxDefault = 2'd0;

  typedef enum logic [1:0] {
    PhHeader,
    PhBody,
    PhDone
  } phase_e;

  typedef enum logic [1:0] {
    NumSkipWs,
    NumDigits,
    NumStopped
  } num_phase_e;

  typedef struct packed {
    num_phase_e phase;
    logic       negative;
  } num_ctl_t;

  typedef struct packed {
    logic       on_status;
    logic       at_line_start;
    logic       name_empty;
    logic       colon_seen;
    logic       skip_colon;
    logic       pending_cr;
    logic [3:0] name_index;
    logic       name_match;
  } line_t;

  localparam line_t LineRst = '{
    on_status: 1'b1, at_line_start: 1'b1, name_empty: 1'b0, colon_seen: 1'b0,
    skip_colon: 1'b0, pending_cr: 1'b0, name_index: 4'd0, name_match: 1'b1
  };

  localparam num_ctl_t NumCtlRst = '{phase: NumSkipWs, negative: 1'b0};

  function automatic logic [7:0] key_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h43; // C
      4'd1:    c = 8'h6F; // o
      4'd2:    c = 8'h6E; // n
      4'd3:    c = 8'h74; // t
      4'd4:    c = 8'h65; // e
      4'd5:    c = 8'h6E; // n
      4'd6:    c = 8'h74; // t
      4'd7:    c = 8'h2D; // -
      4'd8:    c = 8'h4C; // L
      4'd9:    c = 8'h65; // e
      4'd10:   c = 8'h6E; // n
      4'd11:   c = 8'h67; // g
      4'd12:   c = 8'h74; // t
      4'd13:   c = 8'h68; // h
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // One name character against the key; any miss clears the match flag.
  function automatic line_t feed_name(input line_t l, input logic [7:0] b);
    line_t r;
    r = l;
    if (l.name_index < KeyLen && b == key_char(l.name_index)) begin
      r.name_index = l.name_index + 4'd1;
    end else begin
      r.name_match = 1'b0;
    end
    return r;
  endfunction

endpackage

FILE: src/hclp_value_acc.sv
// ----------------------------------------------------------------------------
// hclp_value_acc: decimal value scanner for the header value
// atoi-style step: whitespace skip, sign, digits with saturating x10 + d.
// ----------------------------------------------------------------------------
module hclp_value_acc
  import hclp_pkg::*;
#(
  parameter int LengthBits = LengthBitsDef
) (
  input  logic [7:0]                   byte_i,
  input  logic                         feed_i,
  input  num_ctl_t                     ctl_i,
  input  logic [LengthBits-1:0]        value_i,
  output num_ctl_t                     ctl_o,
  output logic [LengthBits-1:0]        value_o,
  output logic signed [LengthBits-1:0] signed_o
);

  localparam logic [LengthBits-1:0] Cap   = {1'b1, {(LengthBits-1){1'b0}}};
  localparam logic [LengthBits-1:0] CapM1 = Cap - 1'b1;

  logic                  is_digit;
  logic                  is_ws;
  logic [LengthBits+3:0] prod;

  assign is_digit = (byte_i >= ChZero) && (byte_i <= ChNine);
  assign is_ws    = (byte_i == ChSpace) || ((byte_i >= ChTab) && (byte_i <= ChCr));

  // value*10 + digit as two shifts and an add
  assign prod = ({4'b0, value_i} << 3) + ({4'b0, value_i} << 1)
              + (LengthBits+4)'(byte_i[3:0]);

  always_comb begin
    ctl_o   = ctl_i;
    value_o = value_i;
    if (feed_i) begin
      case (ctl_i.phase)
        NumSkipWs: begin
          if (!is_ws) begin
            if (byte_i == ChPlus || byte_i == ChMinus) begin
              ctl_o.negative = (byte_i == ChMinus);
              ctl_o.phase    = NumDigits;
            end else if (is_digit) begin
              value_o     = LengthBits'(byte_i[3:0]);
              ctl_o.phase = NumDigits;
            end else begin
              ctl_o.phase = NumStopped;
            end
          end
        end
        NumDigits: begin
          if (is_digit) begin
            value_o = (prod > (LengthBits+4)'(Cap)) ? Cap : prod[LengthBits-1:0];
          end else begin
            ctl_o.phase = NumStopped;
          end
        end
        default: ;
      endcase
    end
  end

  // Negative values wrap naturally down to -cap; positive ones clamp at cap-1
  always_comb begin
    if (ctl_i.negative) begin
      signed_o = -$signed(value_i);
    end else if (value_i > CapM1) begin
      signed_o = $signed(CapM1);
    end else begin
      signed_o = $signed(value_i);
    end
  end

endmodule

FILE: src/http_header_content_length_parser.sv
// ----------------------------------------------------------------------------
// http_header_content_length_parser: HTTP response header scan and body framing
// Result beats are registered: an accepted byte beat's result shows on m_axis in the next cycle.
// Throughput: one byte beat per cycle, header and body alike, while m_axis keeps taking results.
// A result held in the output register stalls s_axis until m_axis takes it.
// Reset (rst_ni low, async): parser returns to the status line of a new
// response, no output pending, default_length back to 1000000.
// ----------------------------------------------------------------------------
module http_header_content_length_parser
  import hclp_pkg::*;
#(
  parameter int LengthBits = LengthBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte stream in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  logic        s_axis_tuser,  // new_message
  // results out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // [31:0] content_length, [32] length_found,
                                     // [40:33] body_byte, [47:41] zero
  output logic        m_axis_tuser,  // kind: 0 header report, 1 body byte
  output logic        m_axis_tlast,  // last_body
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Effective length holds either the parsed length or the 31-bit default.
  localparam int EffBits = (LengthBits > 32) ? LengthBits : 32;
  localparam logic [LengthBits-1:0] Cap = {1'b1, {(LengthBits-1){1'b0}}};

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic [30:0] default_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == PaddrIdxDefault[0]);
  assign prdata = (paddr[2] == PaddrIdxDefault[0]) ? {1'b0, default_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_q <= DefaultLengthRst;
    end else if (cfg_wr) begin
      default_q <= pwdata[30:0];
    end
  end

  // --------------------------------------------------------------------------
  // Parse state
  // --------------------------------------------------------------------------
  phase_e                      phase_q, phase_d;
  line_t                       line_q, line_d;
  num_ctl_t                    num_ctl_q, num_ctl_d;
  logic [LengthBits-1:0]       num_value_q, num_value_d;
  logic                        found_q, found_d;
  logic signed [LengthBits-1:0] blen_q, blen_d;
  logic signed [EffBits-1:0]   eff_q, eff_d;
  logic [EffBits-1:0]          count_q, count_d;

  // new_message restarts the parse before the byte is looked at
  phase_e                      cur_phase;
  line_t                       cur_line;
  num_ctl_t                    cur_ctl;
  logic [LengthBits-1:0]       cur_value;
  logic                        cur_found;
  logic signed [LengthBits-1:0] cur_blen;
  logic [EffBits-1:0]          cur_count;

  logic [7:0] b;
  logic       s_acc;
  logic       is_colon;
  logic       is_eol;
  logic       feed_en;
  logic       body_last;

  num_ctl_t                     acc_ctl;
  logic [LengthBits-1:0]        acc_value;
  logic signed [LengthBits-1:0] acc_signed;

  // output register
  logic        out_valid_q;
  logic        res_valid;
  logic        res_kind;
  logic [31:0] res_len;
  logic        res_found;
  logic [7:0]  res_byte;
  logic        res_last;
  logic        kind_q, found_out_q, last_q;
  logic [31:0] len_q;
  logic [7:0]  byte_q;

  assign b             = s_axis_tdata;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  assign cur_phase = s_axis_tuser ? PhHeader : phase_q;
  assign cur_line  = s_axis_tuser ? LineRst : line_q;
  assign cur_ctl   = s_axis_tuser ? NumCtlRst : num_ctl_q;
  assign cur_value = s_axis_tuser ? '0 : num_value_q;
  assign cur_found = s_axis_tuser ? 1'b0 : found_q;
  assign cur_blen  = s_axis_tuser ? '0 : blen_q;
  assign cur_count = s_axis_tuser ? '0 : count_q;

  // first colon of a line, and LF right after CR
  assign is_colon = (b == ChColon) && !cur_line.colon_seen;
  assign is_eol   = (b == ChLf) && cur_line.pending_cr;
  assign feed_en  = (cur_phase == PhHeader) && !is_colon && !is_eol
                  && cur_line.colon_seen && !cur_line.skip_colon;

  assign body_last = ((cur_count + 1'b1) == $unsigned(eff_q));

  hclp_value_acc #(
    .LengthBits(LengthBits)
  ) u_value_acc (
    .byte_i   (b),
    .feed_i   (feed_en),
    .ctl_i    (cur_ctl),
    .value_i  (cur_value),
    .ctl_o    (acc_ctl),
    .value_o  (acc_value),
    .signed_o (acc_signed)
  );

  always_comb begin
    phase_d     = phase_q;
    line_d      = line_q;
    num_ctl_d   = num_ctl_q;
    num_value_d = num_value_q;
    found_d     = found_q;
    blen_d      = blen_q;
    eff_d       = eff_q;
    count_d     = count_q;
    res_valid   = 1'b0;
    res_kind    = 1'b0;
    res_len     = eff_q[31:0];
    res_found   = found_q;
    res_byte    = 8'd0;
    res_last    = 1'b0;
    if (s_acc) begin
      phase_d     = cur_phase;
      line_d      = cur_line;
      num_ctl_d   = acc_ctl;
      num_value_d = acc_value;
      found_d     = cur_found;
      blen_d      = cur_blen;
      count_d     = cur_count;
      case (cur_phase)
        PhBody: begin
          // body bytes pass straight through, counted against the length
          count_d   = cur_count + 1'b1;
          res_valid = 1'b1;
          res_kind  = 1'b1;
          res_byte  = b;
          res_last  = body_last;
          if (body_last) begin
            phase_d = PhDone;
          end
        end
        PhHeader: begin
          if (is_colon) begin
            // a CR held back before the colon belongs to the name
            if (cur_line.pending_cr) begin
              line_d = feed_name(line_d, ChCr);
            end
            if (cur_line.at_line_start && !cur_line.pending_cr) begin
              line_d.name_empty = 1'b1;
            end
            line_d.colon_seen    = 1'b1;
            line_d.skip_colon    = 1'b1;
            line_d.pending_cr    = 1'b0;
            line_d.at_line_start = 1'b0;
          end else if (is_eol) begin
            if (cur_line.name_empty || cur_line.at_line_start) begin
              // blank line or leading colon: header done, report the length
              eff_d = cur_found ? EffBits'(cur_blen) : EffBits'(default_q);
              res_valid = 1'b1;
              res_len   = eff_d[31:0];
              res_found = cur_found;
              count_d   = '0;
              if (!eff_d[EffBits-1] && (eff_d != '0)) begin
                phase_d = PhBody;
              end else begin
                phase_d  = PhDone;
                res_last = 1'b1;
              end
            end else begin
              if (!cur_line.on_status && cur_line.name_match
                  && (cur_line.name_index == KeyLen)) begin
                found_d = 1'b1;
                blen_d  = acc_signed;
              end
              line_d           = LineRst;
              line_d.on_status = 1'b0;
              num_ctl_d        = NumCtlRst;
              num_value_d      = '0;
            end
          end else begin
            if (!cur_line.colon_seen) begin
              if (cur_line.pending_cr) begin
                line_d = feed_name(line_d, ChCr);
              end
              if (b != ChCr) begin
                line_d = feed_name(line_d, b);
              end
            end else if (cur_line.skip_colon) begin
              line_d.skip_colon = 1'b0;
            end
            line_d.at_line_start = cur_line.at_line_start && !cur_line.pending_cr
                                 && (b == ChCr);
            line_d.pending_cr    = (b == ChCr);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhHeader;
      line_q      <= LineRst;
      num_ctl_q   <= NumCtlRst;
      num_value_q <= '0;
      found_q     <= 1'b0;
      blen_q      <= '0;
      eff_q       <= '0;
      count_q     <= '0;
    end else begin
      phase_q     <= phase_d;
      line_q      <= line_d;
      num_ctl_q   <= num_ctl_d;
      num_value_q <= num_value_d;
      found_q     <= found_d;
      blen_q      <= blen_d;
      eff_q       <= eff_d;
      count_q     <= count_d;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_acc && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc && res_valid) begin
      kind_q      <= res_kind;
      len_q       <= res_len;
      found_out_q <= res_found;
      byte_q      <= res_byte;
      last_q      <= res_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = kind_q;
  assign m_axis_tlast  = last_q;
  assign m_axis_tdata  = {7'd0, byte_q, found_out_q, len_q};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_name_index_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q.name_index <= KeyLen)
    else $error("name index ran past the key");

  a_number_capped : assert property (@(posedge clk_i) disable iff (!rst_ni)
    num_value_q <= Cap)
    else $error("number value above saturation cap");

  a_body_count_below_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhBody |-> (!eff_q[EffBits-1] && (count_q < $unsigned(eff_q))))
    else $error("body count reached length while still in body");

  a_last_body_ends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && cur_phase == PhBody && body_last) |=>
      (phase_q == PhDone && out_valid_q && m_axis_tlast))
    else $error("final body byte did not close the message");

endmodule

FILE: tb/http_header_content_length_parser_tb.sv
// ----------------------------------------------------------------------------
// http_header_content_length_parser_tb: self-checking bench for the header parser
// Streams HTTP response bytes into the parser and predicts every result beat
// (end-of-header report, body bytes) from its own model of the scan.
// Stimulus is a short directed part, then mostly well-formed random responses
// with odd names, values and line breaks, plus noise. default_length is
// reprogrammed between phases. Sender bursts and receiver stalls are random.
// ----------------------------------------------------------------------------
module http_header_content_length_parser_tb;
  import hclp_pkg::*;

  localparam logic [2:0]   AddrDefaultLen = 3'd0;  // register 0, default_length
  localparam int unsigned  CycleLimit     = 400000;
  localparam int unsigned  StimulusItems  = 1850;  // directed + long body + random
  localparam int unsigned  LongHoldCycles = 400;
  localparam logic [63:0]  SatCap         = 64'h0000_0000_8000_0000;
  localparam logic [111:0] KeyBits        = "Content-Length";

  typedef struct packed {
    logic [7:0] data;
    logic       first;  // new_message
  } stream_byte_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] len;
    logic        found;
    logic [7:0]  data;
    logic        last;
  } result_beat_t;

  typedef enum logic [1:0] {
    RxFree,
    RxCoin,
    RxEveryThird,
    RxMostly
  } rx_mode_e;

  // DUT ports, all inputs known from time zero
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;   // [7:0] data_byte
  logic        s_axis_tuser  = 1'b0; // new_message
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;         // [31:0] content_length, [32] length_found,
                                     // [40:33] body_byte, [47:41] zero
  logic        m_axis_tuser;         // kind
  logic        m_axis_tlast;         // last_body
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  // Byte beats waiting to be sent and result beats waiting to arrive
  stream_byte_t pending_q[$];
  result_beat_t expected_q[$];
  int unsigned  items_sent   = 0;
  logic         msg_first    = 1'b0;
  int unsigned  errors       = 0;
  int unsigned  cycle_count  = 0;

  // Sender burst shaping
  int unsigned gap_left   = 0;
  int unsigned burst_left = 0;

  // Receiver stall shaping; hold_req is bumped by the stimulus to ask for a
  // long hold-off, the receiver counts it out itself.
  int unsigned hold_req   = 0;
  int unsigned hold_seen  = 0;
  int unsigned hold_left  = 0;
  int unsigned mode_left  = 0;
  int unsigned rdy_tick   = 0;
  rx_mode_e    stall_mode = RxFree;

  // Predictor state
  logic [30:0] dflt_len;
  phase_e      msg_phase;
  logic        status_line, line_start, name_blank, colon_hit;
  logic        skip_next, cr_held, key_ok;
  logic [3:0]  key_idx;
  num_phase_e  num_ph;
  logic        num_neg;
  logic [63:0] num_acc;
  logic        len_found;
  longint      hdr_len, body_seen, eff_len;

  http_header_content_length_parser dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // per-line scan state back to the start of a header line
  function automatic void clear_line();
    line_start = 1'b1;
    name_blank = 1'b0;
    colon_hit  = 1'b0;
    skip_next  = 1'b0;
    cr_held    = 1'b0;
    key_idx    = '0;
    key_ok     = 1'b1;
    num_ph     = NumSkipWs;
    num_neg    = 1'b0;
    num_acc    = '0;
  endfunction

  // whole response restart; default_length survives
  function automatic void restart_parse();
    msg_phase   = PhHeader;
    status_line = 1'b1;
    clear_line();
    len_found   = 1'b0;
    hdr_len     = 0;
    body_seen   = 0;
    eff_len     = 0;
  endfunction

  // one name byte against "Content-Length"; a miss sticks
  function automatic void match_key(input logic [7:0] b);
    if (key_idx < KeyLen &&
        b == KeyBits[8 * (int'(KeyLen) - 1 - int'(key_idx)) +: 8]) begin
      key_idx = key_idx + 4'd1;
    end else begin
      key_ok = 1'b0;
    end
  endfunction

  function automatic result_beat_t make_beat(input logic kind, input logic [7:0] b,
                                             input logic last);
    result_beat_t r;
    r.kind  = kind;
    r.len   = eff_len[31:0];
    r.found = len_found;
    r.data  = b;
    r.last  = last;
    return r;
  endfunction

  // Advances the model by one accepted byte; returns 1 when a result beat is due.
  function automatic bit predict_result(input logic [7:0] b, input logic nm,
                                        output result_beat_t r);
    logic        is_digit;
    logic [63:0] dv;
    r        = '0;
    is_digit = (b >= ChZero && b <= ChNine);
    dv       = {56'd0, b - ChZero};
    if (nm) restart_parse();

    if (msg_phase == PhBody) begin
      body_seen++;
      r = make_beat(1'b1, b, body_seen >= eff_len);
      if (body_seen >= eff_len) msg_phase = PhDone;
      return 1'b1;
    end
    // done phase swallows bytes until new_message
    if (msg_phase != PhHeader) return 1'b0;

    // first colon of the line splits name and value
    if (b == ChColon && !colon_hit) begin
      if (cr_held) match_key(ChCr);
      if (line_start && !cr_held) name_blank = 1'b1;
      colon_hit  = 1'b1;
      skip_next  = 1'b1;
      cr_held    = 1'b0;
      line_start = 1'b0;
      return 1'b0;
    end

    // CR LF: end of line, or end of header on a blank / colon-led line
    if (b == ChLf && cr_held) begin
      if (name_blank || line_start) begin
        eff_len = len_found ? hdr_len : longint'(dflt_len);
        if (eff_len > 0) begin
          msg_phase = PhBody;
          body_seen = 0;
          r = make_beat(1'b0, 8'h00, 1'b0);
        end else begin
          msg_phase = PhDone;
          r = make_beat(1'b0, 8'h00, 1'b1);
        end
        return 1'b1;
      end
      if (!status_line && key_ok && key_idx == KeyLen) begin
        len_found = 1'b1;
        if (num_neg) hdr_len = -longint'(num_acc);
        else if (num_acc > SatCap - 64'd1) hdr_len = longint'(SatCap - 64'd1);
        else hdr_len = longint'(num_acc);
      end
      status_line = 1'b0;
      clear_line();
      return 1'b0;
    end

    if (!colon_hit) begin
      // a held CR that was not followed by LF is a plain name byte
      if (cr_held) match_key(ChCr);
      if (b != ChCr) match_key(b);
    end else if (skip_next) begin
      skip_next = 1'b0;
    end else if (num_ph == NumSkipWs) begin
      if (b == ChPlus || b == ChMinus) begin
        num_neg = (b == ChMinus);
        num_ph  = NumDigits;
      end else if (is_digit) begin
        num_acc = dv;
        num_ph  = NumDigits;
      end else if (b != ChSpace && !(b >= ChTab && b <= ChCr)) begin
        num_ph = NumStopped;
      end
    end else if (num_ph == NumDigits) begin
      if (is_digit) begin
        num_acc = num_acc * 64'd10 + dv;
        if (num_acc > SatCap) num_acc = SatCap;
      end else begin
        num_ph = NumStopped;
      end
    end
    line_start = line_start && !cr_held && b == ChCr;
    cr_held    = (b == ChCr);
    return 1'b0;
  endfunction

  function automatic string beat_str(input result_beat_t x);
    return $sformatf("kind=%0d len=%0d found=%0d byte=%02h last=%0d",
                     x.kind, $signed(x.len), x.found, x.data, x.last);
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers: they only queue bytes, the driver sends them
  // --------------------------------------------------------------------------

  // the first byte queued after msg_first is set carries new_message
  task automatic push_byte(input logic [7:0] b);
    stream_byte_t it;
    it.data   = b;
    it.first  = msg_first;
    msg_first = 1'b0;
    pending_q.push_back(it);
    items_sent++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  task automatic push_crlf();
    push_byte(ChCr);
    push_byte(ChLf);
  endtask

  task automatic push_body(input int unsigned n);
    repeat (n) push_byte(8'($urandom_range(0, 255)));
  endtask

  // byte right after the colon is dropped by the parser, so it may be anything
  task automatic push_sep();
    if ($urandom_range(0, 4) == 0) push_byte(8'($urandom_range(0, 255)));
    else push_byte(ChSpace);
  endtask

  task automatic push_value();
    logic [2:0] w;
    // optional leading whitespace, CR among it (a lone CR in the value)
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        w = 3'($urandom_range(0, 5));
        push_byte(w == 3'd5 ? ChSpace : ChTab + 8'(w));
      end
    end
    case ($urandom_range(0, 13))
      0, 1, 2, 3, 4, 5: push_text($sformatf("%0d", $urandom_range(0, 40)));
      6:  push_text($sformatf("-%0d", $urandom_range(0, 60)));
      7:  push_text($sformatf("+%0d", $urandom_range(0, 40)));
      8: begin
        // saturation edges and sign corners
        case ($urandom_range(0, 5))
          0:       push_text("2147483647");
          1:       push_text("2147483648");
          2:       push_text("-2147483648");
          3:       push_text("-2147483649");
          4:       push_text("0000000000007");
          default: push_text("-0");
        endcase
      end
      9:  push_text($sformatf("%0d;q", $urandom_range(0, 40)));
      10: push_text("x12");
      12: push_text($sformatf("%0d", $urandom_range(0, 32'h7FFF_FFFF)));
      13: push_text($sformatf("%0d%0d", $urandom, $urandom));
      default: begin
        // empty value
      end
    endcase
  endtask

  task automatic push_header();
    case ($urandom_range(0, 10))
      0, 1, 2, 3: begin
        push_text("Content-Length:");
        push_sep();
        push_value();
      end
      4: begin
        // names that almost match the key
        case ($urandom_range(0, 4))
          0:       push_text("content-length");
          1:       push_text("Content-Lengt");
          2:       push_text("Content-Lengthh");
          3:       push_text("XContent-Length");
          default: push_text("Content-Length ");
        endcase
        push_byte(ChColon);
        push_sep();
        push_value();
      end
      // line without a colon: the whole line is the name, value reads as 0
      5: push_text("Content-Length");
      6: begin
        // no value before the line end, at most the dropped byte after the colon
        push_text("Content-Length:");
        if ($urandom_range(0, 1) == 1) push_byte(8'($urandom_range(0, 255)));
      end
      7: begin
        // lone CR inside the name or inside the digits
        if ($urandom_range(0, 1) == 1) begin
          push_text("Content-Le");
          push_byte(ChCr);
          push_text("ngth: 9");
        end else begin
          push_text("Content-Length: 1");
          push_byte(ChCr);
          push_text("2");
        end
      end
      8: begin
        // NUL is an ordinary byte
        if ($urandom_range(0, 1) == 1) begin
          push_text("Content-Length: ");
          push_byte(8'h00);
          push_text("5");
        end else begin
          push_text("Content");
          push_byte(8'h00);
          push_text(": 6");
        end
      end
      9: push_text("Host: h");
      default: repeat ($urandom_range(1, 8)) push_byte(8'($urandom_range(0, 255)));
    endcase
    push_crlf();
  endtask

  task automatic push_message();
    msg_first = 1'b1;
    case ($urandom_range(0, 9))
      0: begin
        // empty status line ends the header at once
      end
      1:       push_text("H");
      2:       push_text("Content-Length: 3");  // ignored on the status line
      3:       push_text("HTTP:1");
      default: push_text("HTTP/1.1 200 OK");
    endcase
    push_crlf();
    repeat ($urandom_range(0, 4)) push_header();
    // cut short now and then; the next response restarts the parse
    if ($urandom_range(0, 9) == 0) return;
    // a colon-led line also closes the header
    if ($urandom_range(0, 7) == 0) begin
      push_byte(ChColon);
      push_text("z");
    end
    push_crlf();
    push_body($urandom_range(0, 5) == 0 ? $urandom_range(20, 60) : $urandom_range(0, 14));
  endtask

  task automatic push_noise();
    repeat ($urandom_range(4, 30)) begin
      msg_first = ($urandom_range(0, 11) == 0);
      case ($urandom_range(0, 5))
        0:       push_byte(ChCr);
        1:       push_byte(ChLf);
        2:       push_byte(ChColon);
        default: push_byte(8'($urandom));
      endcase
    end
  endtask

  // --------------------------------------------------------------------------
  // Configuration access (stimulus process only, block idle)
  // --------------------------------------------------------------------------

  // read back default_length; sampled mid access cycle
  task automatic check_default_reg();
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= AddrDefaultLen;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    if (prdata !== {1'b0, dflt_len}) begin
      errors++;
      $display("%0t: default_length readback mismatch: expected %08h, got %08h",
               $time, {1'b0, dflt_len}, prdata);
    end
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_default(input logic [30:0] v);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrDefaultLen;
    // bit 31 is outside the register and must be dropped
    pwdata  <= {1'($urandom_range(0, 1)), v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);  // write lands on this edge
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    dflt_len = v;
    check_default_reg();
  endtask

  // sender paused until the queue is empty and every result is back, then
  // an extra wait lets a byte that gave no result finish
  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_q.size() != 0 || s_axis_tvalid || expected_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned batch_end;
    dflt_len = DefaultLengthRst;
    restart_parse();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_default_reg();

    // Directed: empty status line ends the header, report with the reset
    // default and one body byte 0xFF.
    msg_first = 1'b1;
    push_crlf();
    push_byte(8'hFF);
    // Two body bytes (NUL and 0x80), the last one marked, then a byte in the
    // done phase that gives nothing.
    msg_first = 1'b1;
    push_text("H");
    push_crlf();
    push_text("Content-Length: 2");
    push_crlf();
    push_crlf();
    push_byte(8'h00);
    push_byte(8'h80);
    push_byte(ChCr);
    wait_drained();

    // default 0: reports without a length close at once
    set_default(31'd0);
    repeat (6) push_message();
    wait_drained();

    // largest default: the body only ends at the next response
    set_default(31'h7FFF_FFFF);
    repeat (6) push_message();
    wait_drained();

    // Long receiver hold-off while a long body is offered, so the output
    // register fills and the input backs up.
    set_default(31'd12);
    hold_req++;
    msg_first = 1'b1;
    push_text("H");
    push_crlf();
    push_text("Content-Length: 500");
    push_crlf();
    push_crlf();
    push_body(500);

    // random phases, each with its own default_length
    while (items_sent < StimulusItems) begin
      batch_end = items_sent + 250;
      if (batch_end > StimulusItems) batch_end = StimulusItems;
      while (items_sent < batch_end) begin
        if ($urandom_range(0, 9) == 0) push_noise();
        else push_message();
      end
      wait_drained();
      case ($urandom_range(0, 3))
        0:       set_default(31'($urandom_range(1, 30)));
        1:       set_default(31'd0);
        2:       set_default(31'($urandom));
        default: set_default(31'($urandom_range(31, 200)));
      endcase
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driver: bursts of random length with random gaps; a beat holds until taken
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : driver
    stream_byte_t cur;
    if (rst_ni && (!s_axis_tvalid || s_axis_tready)) begin
      if (gap_left != 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_q.size() != 0) begin
        cur = pending_q.pop_front();
        s_axis_tdata  <= cur.data;
        s_axis_tuser  <= cur.first;
        s_axis_tvalid <= 1'b1;
        if (burst_left != 0) begin
          burst_left--;
        end else begin
          // some bursts run back to back with no gap at all
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: stall pattern is redrawn when its random run ends; long hold on request
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : receiver
    if (rst_ni) begin
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = LongHoldCycles;
        m_axis_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          stall_mode = rx_mode_e'($urandom_range(0, 3));
          mode_left  = $urandom_range(16, 128);
        end else begin
          mode_left--;
        end
        rdy_tick++;
        case (stall_mode)
          RxFree:       m_axis_tready <= 1'b1;
          RxCoin:       m_axis_tready <= 1'($urandom_range(0, 1));
          RxEveryThird: m_axis_tready <= (rdy_tick % 3) != 0;
          default:      m_axis_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check result beats against the oldest prediction, then predict
  // for the byte beat taken on the same edge
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    result_beat_t got, want, nxt;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind  = m_axis_tuser;
        got.len   = m_axis_tdata[31:0];
        got.found = m_axis_tdata[32];
        got.data  = m_axis_tdata[40:33];
        got.last  = m_axis_tlast;
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat: expected none, got %s",
                   $time, beat_str(got));
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: result mismatch: expected %s, got %s",
                     $time, beat_str(want), beat_str(got));
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (predict_result(s_axis_tdata, s_axis_tuser, nxt)) expected_q.push_back(nxt);
      end
    end
  end

  // hang guard
  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: cycle limit reached, %0d result beats outstanding",
               $time, expected_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule

FILE: filelist.f
src/hclp_pkg.sv
src/hclp_value_acc.sv
src/http_header_content_length_parser.sv
tb/http_header_content_length_parser_tb.sv
